// File: rtl/epp_pkg.sv
// Shared types and constants for the expert prefetch predictor.
// No dependencies; imported by every module of the block except epp_ram.
`timescale 1ns / 1ps

package epp_pkg;

    // Storage geometry
    localparam int MAX_LAYERS  = 32;
    localparam int MAX_LEN     = 128;
    localparam int WINDOW      = 4;
    localparam int MAX_EXPERTS = 64;
    localparam int MAX_TOPK    = 8;

    localparam int LAYER_W = 5;
    localparam int EXP_W   = 6;
    localparam int IDX_W   = 7;
    localparam int SLOT_W  = 2;
    localparam int LEN_W   = 8;   // holds MAX_LEN itself
    localparam int CNT_W   = 7;   // holds MAX_EXPERTS itself
    localparam int K_W     = 4;   // holds MAX_TOPK itself
    localparam int RANK_W  = 3;
    localparam int NL_W    = 6;

    localparam int HIST_DEPTH = MAX_LAYERS * WINDOW * MAX_LEN;
    localparam int HIST_AW    = LAYER_W + SLOT_W + IDX_W;
    localparam int VEC_DEPTH  = MAX_LAYERS * MAX_LEN;
    localparam int VEC_AW     = LAYER_W + IDX_W;
    localparam int WGT_DEPTH  = MAX_LAYERS * MAX_EXPERTS * MAX_LEN;
    localparam int ACC_W      = 48;

    // Item kinds
    localparam logic [1:0] CMD_ACT  = 2'd0;
    localparam logic [1:0] CMD_PRED = 2'd1;
    localparam logic [1:0] CMD_WGT  = 2'd2;
    localparam logic [1:0] CMD_CNT  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_LAYERS = 2'd0;
    localparam logic [1:0] CFG_VECTOR_LEN = 2'd1;
    localparam logic [1:0] CFG_TOP_K      = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [LAYER_W-1:0] layer;
        logic [EXP_W-1:0]   expert;
        logic [IDX_W-1:0]   index;
        logic signed [15:0] value;
        logic               last;
    } epp_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] logit;
        logic [EXP_W-1:0]        id;
    } epp_entry_t;

    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic               zero;
        logic [EXP_W-1:0]   e;
    } epp_tag_t;

    // Controller to datapath
    typedef struct packed {
        logic                clear_wr;
        logic [HIST_AW-1:0]  clr_addr;
        logic                capture;
        logic                act_rd;
        logic                act_wr;
        logic                wr_weight;
        logic                wr_count;
        logic                mac_issue;
        logic                mac_first;
        logic                mac_last;
        logic                mac_zero;
        logic [EXP_W-1:0]    mac_exp;
        logic [IDX_W-1:0]    mac_idx;
        logic                sel_rd;
        logic                sel_first;
        logic [EXP_W-1:0]    sel_pos;
        logic [RANK_W-1:0]   rank;
        logic                swap_a;
        logic                swap_b;
        logic                emit_ok;
        logic                emit_err;
        logic                emit_last;
    } epp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0]        item_cmd;
        logic              layer_ok;
        logic [LEN_W-1:0]  n_len;
        logic [CNT_W-1:0]  n_exp;
        logic [K_W-1:0]    k;
        logic              pipe_busy;
        logic              sel_busy;
        logic              out_busy;
    } epp_sts_t;

endpackage

// File: rtl/epp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module epp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/epp_ctrl.sv
// Controller: sequences clearing, item decode, the MAC sweep, selection and result emission.
// Depends on epp_pkg; drives the datapath through epp_cmd_t.
`timescale 1ns / 1ps

module epp_ctrl
    import epp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  epp_sts_t sts,
    output epp_cmd_t cmd
);

    typedef enum logic [11:0] {
        ST_CLEAR     = 12'b000000000001,
        ST_IDLE      = 12'b000000000010,
        ST_DECODE    = 12'b000000000100,
        ST_ACT_WR    = 12'b000000001000,
        ST_MAC       = 12'b000000010000,
        ST_MAC_DRAIN = 12'b000000100000,
        ST_SEL_RD    = 12'b000001000000,
        ST_SEL_SCAN  = 12'b000010000000,
        ST_SEL_DRAIN = 12'b000100000000,
        ST_SWAP_A    = 12'b001000000000,
        ST_SWAP_B    = 12'b010000000000,
        ST_EMIT      = 12'b100000000000
    } epp_state_t;

    epp_state_t         state_reg, state_next;
    logic [HIST_AW-1:0] clr_reg, clr_next;
    logic [EXP_W-1:0]   e_reg, e_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [RANK_W-1:0]  rnd_reg, rnd_next;
    logic [EXP_W-1:0]   j_reg, j_next;

    logic i_last, e_last, rnd_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign i_last   = (sts.n_len == '0) || ({1'b0, i_reg} == sts.n_len - LEN_W'(1));
    assign e_last   = ({1'b0, e_reg} == sts.n_exp - CNT_W'(1));
    assign rnd_last = ({1'b0, rnd_reg} + K_W'(1) == sts.k);

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        e_next     = e_reg;
        i_next     = i_reg;
        rnd_next   = rnd_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.clr_addr  = clr_reg;
        cmd.mac_exp   = e_reg;
        cmd.mac_idx   = i_reg;
        cmd.mac_first = (i_reg == '0);
        cmd.mac_last  = i_last;
        cmd.mac_zero  = (sts.n_len == '0);
        cmd.rank      = rnd_reg;
        cmd.sel_pos   = j_reg;
        cmd.emit_last = rnd_last;
        cmd.capture   = s_tvalid && s_tready;

        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                clr_next = clr_reg + HIST_AW'(1);
                if (clr_reg == HIST_AW'(HIST_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.act_rd = 1'b1;
                unique case (sts.item_cmd)
                    CMD_ACT: begin
                        state_next = sts.layer_ok ? ST_ACT_WR : ST_IDLE;
                    end
                    CMD_WGT: begin
                        cmd.wr_weight = 1'b1;
                        state_next = ST_IDLE;
                    end
                    CMD_CNT: begin
                        cmd.wr_count = 1'b1;
                        state_next = ST_IDLE;
                    end
                    CMD_PRED: begin
                        // hold until the previous result has left
                        if (!sts.out_busy) begin
                            if (!sts.layer_ok) begin
                                cmd.emit_err = 1'b1;
                                state_next = ST_IDLE;
                            end else if (sts.k == '0) begin
                                state_next = ST_IDLE;
                            end else begin
                                e_next = '0;
                                i_next = '0;
                                state_next = ST_MAC;
                            end
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_ACT_WR: begin
                cmd.act_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MAC: begin
                cmd.mac_issue = 1'b1;
                if (i_last) begin
                    i_next = '0;
                    e_next = e_reg + EXP_W'(1);
                    if (e_last) begin
                        state_next = ST_MAC_DRAIN;
                    end
                end else begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            ST_MAC_DRAIN: begin
                if (!sts.pipe_busy) begin
                    rnd_next = '0;
                    state_next = ST_SEL_RD;
                end
            end
            ST_SEL_RD: begin
                cmd.sel_rd    = 1'b1;
                cmd.sel_first = 1'b1;
                cmd.sel_pos   = EXP_W'(rnd_reg);
                j_next = EXP_W'(rnd_reg) + EXP_W'(1);
                if ({4'b0, rnd_reg} + CNT_W'(1) < sts.n_exp) begin
                    state_next = ST_SEL_SCAN;
                end else begin
                    state_next = ST_SEL_DRAIN;
                end
            end
            ST_SEL_SCAN: begin
                cmd.sel_rd = 1'b1;
                j_next = j_reg + EXP_W'(1);
                if ({1'b0, j_reg} == sts.n_exp - CNT_W'(1)) begin
                    state_next = ST_SEL_DRAIN;
                end
            end
            ST_SEL_DRAIN: begin
                if (!sts.sel_busy) begin
                    state_next = ST_SWAP_A;
                end
            end
            ST_SWAP_A: begin
                cmd.swap_a = 1'b1;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                cmd.swap_b  = 1'b1;
                cmd.emit_ok = 1'b1;
                state_next = rnd_last ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (!sts.out_busy) begin
                    rnd_next = rnd_reg + RANK_W'(1);
                    state_next = ST_SEL_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            e_reg     <= '0;
            i_reg     <= '0;
            rnd_reg   <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            e_reg     <= e_next;
            i_reg     <= i_next;
            rnd_reg   <= rnd_next;
            j_reg     <= j_next;
        end
    end

endmodule

// File: rtl/epp_dp.sv
// Datapath: config registers, history/difference/weight memories, MAC pipeline,
// selection scratch and the result register. Depends on epp_pkg and epp_ram.
`timescale 1ns / 1ps

module epp_dp
    import epp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  epp_cmd_t    cmd,
    output epp_sts_t    sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    logic [NL_W-1:0]  nl_reg;
    logic [LEN_W-1:0] vl_reg;
    logic [K_W-1:0]   tk_reg;
    epp_item_t        item_reg;
    logic [CNT_W-1:0] cnt_reg [MAX_LAYERS];
    logic [SLOT_W-1:0] head_reg;

    logic [NL_W-1:0]  eff_l;
    logic [LEN_W-1:0] eff_n;
    logic [K_W-1:0]   kk;
    logic [CNT_W-1:0] n_exp;
    logic             idx_ok;
    logic             adv;
    logic [SLOT_W-1:0] prev_slot, pprev_slot, head_inc;

    // ---- configuration and item capture ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nl_reg <= NL_W'(1);
            vl_reg <= LEN_W'(MAX_LEN);
            tk_reg <= K_W'(2);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NUM_LAYERS: nl_reg <= cfg_wdata[NL_W-1:0];
                CFG_VECTOR_LEN: vl_reg <= cfg_wdata[LEN_W-1:0];
                CFG_TOP_K:      tk_reg <= cfg_wdata[K_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg.cmd    <= s_tuser;
            item_reg.layer  <= s_tdata[4:0];
            item_reg.expert <= s_tdata[10:5];
            item_reg.index  <= s_tdata[17:11];
            item_reg.value  <= s_tdata[33:18];
            item_reg.last   <= s_tlast;
        end
    end

    assign eff_l = (nl_reg > NL_W'(MAX_LAYERS)) ? NL_W'(MAX_LAYERS) : nl_reg;
    assign eff_n = (vl_reg > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : vl_reg;
    assign kk    = (tk_reg > K_W'(MAX_TOPK)) ? K_W'(MAX_TOPK) : tk_reg;
    assign n_exp = cnt_reg[item_reg.layer];
    assign idx_ok = ({1'b0, item_reg.index} < eff_n);
    assign adv   = item_reg.last && ({1'b0, item_reg.layer} == eff_l - NL_W'(1));

    assign prev_slot  = (head_reg == '0) ? SLOT_W'(WINDOW - 1) : head_reg - SLOT_W'(1);
    assign pprev_slot = (prev_slot == '0) ? SLOT_W'(WINDOW - 1) : prev_slot - SLOT_W'(1);
    assign head_inc   = (head_reg == SLOT_W'(WINDOW - 1)) ? '0 : head_reg + SLOT_W'(1);

    // expert counts load clamped to [0, MAX_EXPERTS]
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < MAX_LAYERS; l++) begin
                cnt_reg[l] <= '0;
            end
            head_reg <= '0;
        end else begin
            if (cmd.wr_count) begin
                if (item_reg.value < 0) begin
                    cnt_reg[item_reg.layer] <= '0;
                end else if (item_reg.value > 16'sd64) begin
                    cnt_reg[item_reg.layer] <= CNT_W'(MAX_EXPERTS);
                end else begin
                    cnt_reg[item_reg.layer] <= item_reg.value[CNT_W-1:0];
                end
            end
            if (cmd.act_wr && adv) begin
                head_reg <= head_inc;
            end
        end
    end

    // ---- memories ----
    logic [HIST_AW-1:0] hist_waddr, hist_raddr_a, hist_raddr_b;
    logic [15:0]        hist_wdata, hist_a_q, hist_b_q;
    logic               hist_we, vec_we;
    logic [VEC_AW-1:0]  vec_waddr, vec_raddr;
    logic [16:0]        vel_wdata, vel_q;
    logic [17:0]        acc_wdata, acc_q;
    logic [15:0]        wgt_q;
    logic signed [16:0] act_v;
    logic signed [17:0] act_a;

    assign act_v = 17'(item_reg.value) - 17'(signed'(hist_a_q));
    assign act_a = 18'(act_v) - (18'(signed'(hist_a_q)) - 18'(signed'(hist_b_q)));

    assign hist_we    = cmd.clear_wr || (cmd.act_wr && idx_ok);
    assign vec_we     = hist_we;
    assign hist_waddr = cmd.clear_wr ? cmd.clr_addr
                                     : {item_reg.layer, head_reg, item_reg.index};
    assign hist_wdata = cmd.clear_wr ? '0 : item_reg.value;
    assign vec_waddr  = cmd.clear_wr ? cmd.clr_addr[VEC_AW-1:0]
                                     : {item_reg.layer, item_reg.index};
    assign vel_wdata  = cmd.clear_wr ? '0 : act_v;
    assign acc_wdata  = cmd.clear_wr ? '0 : act_a;
    assign hist_raddr_a = cmd.act_rd ? {item_reg.layer, prev_slot, item_reg.index}
                                     : {item_reg.layer, prev_slot, cmd.mac_idx};
    assign hist_raddr_b = {item_reg.layer, pprev_slot, item_reg.index};
    assign vec_raddr    = {item_reg.layer, cmd.mac_idx};

    epp_ram #(.WIDTH(16), .DEPTH(HIST_DEPTH)) u_hist_a (
        .aclk(aclk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
        .raddr(hist_raddr_a), .rdata(hist_a_q)
    );
    epp_ram #(.WIDTH(16), .DEPTH(HIST_DEPTH)) u_hist_b (
        .aclk(aclk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
        .raddr(hist_raddr_b), .rdata(hist_b_q)
    );
    epp_ram #(.WIDTH(17), .DEPTH(VEC_DEPTH)) u_vel (
        .aclk(aclk), .we(vec_we), .waddr(vec_waddr), .wdata(vel_wdata),
        .raddr(vec_raddr), .rdata(vel_q)
    );
    epp_ram #(.WIDTH(18), .DEPTH(VEC_DEPTH)) u_acc (
        .aclk(aclk), .we(vec_we), .waddr(vec_waddr), .wdata(acc_wdata),
        .raddr(vec_raddr), .rdata(acc_q)
    );
    epp_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH)) u_wgt (
        .aclk(aclk), .we(cmd.wr_weight),
        .waddr({item_reg.layer, item_reg.expert, item_reg.index}),
        .wdata(item_reg.value),
        .raddr({item_reg.layer, cmd.mac_exp, cmd.mac_idx}), .rdata(wgt_q)
    );

    // ---- MAC pipeline: read, estimate, multiply, accumulate ----
    epp_tag_t t1_reg, t2_reg, t3_reg;
    logic signed [15:0] est_reg, w_reg;
    logic signed [31:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [18:0] est_sum;
    logic signed [15:0] est_sat;

    assign est_sum = 19'(signed'(hist_a_q)) + 19'(signed'(vel_q))
                   + 19'(signed'(acc_q) >>> 1);
    assign est_sat = (est_sum > 19'sd32767)  ? 16'sh7FFF :
                     (est_sum < -19'sd32768) ? 16'sh8000 : est_sum[15:0];
    assign acc_next = (t3_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
        end else begin
            t1_reg <= '{valid: cmd.mac_issue, first: cmd.mac_first, last: cmd.mac_last,
                        zero: cmd.mac_zero, e: cmd.mac_exp};
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        // zero length vector gives a zero logit
        est_reg  <= t1_reg.zero ? '0 : est_sat;
        w_reg    <= t1_reg.zero ? '0 : signed'(wgt_q);
        prod_reg <= est_reg * w_reg;
        if (t3_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    // ---- selection scratch: logits by position, swapped in place ----
    epp_entry_t sort_q, sort_wdata, cur_reg, best_reg;
    logic [EXP_W-1:0] sort_waddr, best_pos_reg;
    logic             sort_we;
    logic             sv_valid_reg, sv_first_reg;
    logic [EXP_W-1:0] sv_pos_reg;

    always_comb begin
        sort_we    = 1'b1;
        sort_waddr = t3_reg.e;
        sort_wdata = '{logit: acc_next, id: t3_reg.e};
        priority if (t3_reg.valid && t3_reg.last) begin
            sort_we = 1'b1;
        end else if (cmd.swap_a) begin
            sort_waddr = EXP_W'(cmd.rank);
            sort_wdata = best_reg;
        end else if (cmd.swap_b) begin
            sort_waddr = best_pos_reg;
            sort_wdata = cur_reg;
        end else begin
            sort_we = 1'b0;
        end
    end

    epp_ram #(.WIDTH(ACC_W + EXP_W), .DEPTH(MAX_EXPERTS)) u_sort (
        .aclk(aclk), .we(sort_we), .waddr(sort_waddr), .wdata(sort_wdata),
        .raddr(cmd.sel_pos), .rdata(sort_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_valid_reg <= 1'b0;
        end else begin
            sv_valid_reg <= cmd.sel_rd;
        end
    end

    always_ff @(posedge aclk) begin
        sv_first_reg <= cmd.sel_first;
        sv_pos_reg   <= cmd.sel_pos;
        if (sv_valid_reg) begin
            if (sv_first_reg) begin
                cur_reg      <= sort_q;
                best_reg     <= sort_q;
                best_pos_reg <= sv_pos_reg;
            end else if (sort_q.logit > best_reg.logit) begin
                best_reg     <= sort_q;
                best_pos_reg <= sv_pos_reg;
            end
        end
    end

    // ---- result register ----
    logic                 out_valid_reg, out_status_reg, out_eor_reg;
    logic [EXP_W-1:0]     out_id_reg;
    logic [RANK_W-1:0]    out_rank_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_ok || cmd.emit_err) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_err) begin
            out_id_reg     <= '0;
            out_rank_reg   <= '0;
            out_status_reg <= 1'b1;
            out_eor_reg    <= 1'b1;
        end else if (cmd.emit_ok) begin
            out_id_reg     <= best_reg.id;
            out_rank_reg   <= cmd.rank;
            out_status_reg <= 1'b0;
            out_eor_reg    <= cmd.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_rank_reg, out_id_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_eor_reg;

    // ---- status ----
    assign sts.item_cmd  = item_reg.cmd;
    assign sts.layer_ok  = ({1'b0, item_reg.layer} < eff_l);
    assign sts.n_len     = eff_n;
    assign sts.n_exp     = n_exp;
    assign sts.k         = ({3'b0, kk} > n_exp) ? n_exp[K_W-1:0] : kk;
    assign sts.pipe_busy = t1_reg.valid || t2_reg.valid || t3_reg.valid;
    assign sts.sel_busy  = sv_valid_reg;
    assign sts.out_busy  = out_valid_reg;

    // ---- checks ----
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_ok || cmd.emit_err) |-> !out_valid_reg)
        else $error("result register loaded while full");

    a_mac_sel_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sts.pipe_busy && (sv_valid_reg || cmd.sel_rd)))
        else $error("selection overlaps MAC pipeline");

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        (t3_reg.valid && t3_reg.last) |-> !(cmd.swap_a || cmd.swap_b))
        else $error("scratch write conflict");

endmodule

// File: rtl/expert_prefetch_predictor_unit.sv
// Expert prefetch predictor: one item at a time; after reset a clearing pass over
// every history entry zeroes the history and differences while no item is accepted.
// Predict: a MAC sweep and drain, then per rank a scan and swap, with an output
// handoff between ranks that waits while the previous result is still held.
// Reset: synchronous, active low on aresetn. Depends on epp_pkg, epp_ctrl, epp_dp.
`timescale 1ns / 1ps

module expert_prefetch_predictor_unit
    import epp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // layer[4:0] expert[10:5] index[17:11] value[33:18]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sel_id[5:0] rank[8:6]
    output logic        m_tuser,   // status[0]
    output logic        m_tlast
);

    epp_cmd_t cmd;
    epp_sts_t sts;

    epp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    epp_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
        .cmd(cmd), .sts(sts),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule
